// ----- sv/xxtea_pkg.sv -----
`timescale 1ns / 1ps

package xxtea_pkg;

	localparam int unsigned MAX_WORDS_DEF = 64;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned ROUND_W = 6;
	localparam int unsigned BASE_ROUNDS = 6;
	localparam int unsigned ROUND_NUM = 52;
	localparam int unsigned QUOT_MAX = ROUND_NUM / 2;
	localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

	typedef logic [1:0] status_t;
	localparam status_t STAT_DONE  = 2'd0;
	localparam status_t STAT_SHORT = 2'd1;
	localparam status_t STAT_LONG  = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] data_word;
		logic              last_word;
		logic              decrypt_mode;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_word;
		logic              last_result;
		status_t           block_status;
	} out_item_t;

	typedef logic [3:0][WORD_W-1:0] key_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SETUP,
		ST_PRIME,
		ST_RUN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic    load_wr;
		logic    load_first;
		logic    init;
		logic    sum_init;
		logic    rd_en;
		logic    step;
		logic    round_end;
		logic    decrypt;
		logic    pair;
		logic    out_load;
		logic    out_last;
		status_t out_status;
		logic [1:0] key_lo;
	} dp_cmd_t;

	function automatic logic [WORD_W-1:0] mix(
		input logic [WORD_W-1:0] z,
		input logic [WORD_W-1:0] y,
		input logic [WORD_W-1:0] sum,
		input logic [WORD_W-1:0] k
	);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
		b = (sum ^ y) + (k ^ z);
		return a ^ b;
	endfunction

endpackage

// ----- sv/xxtea_apb.sv -----
`timescale 1ns / 1ps

module xxtea_apb (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [xxtea_pkg::ADDR_W-1:0]         paddr,
	input  logic [xxtea_pkg::WORD_W-1:0]         pwdata,
	output logic [xxtea_pkg::WORD_W-1:0]         prdata,
	output logic                                 pready,
	output xxtea_pkg::key_t                      key
);

	xxtea_pkg::key_t key_q;
	logic [1:0]      reg_idx;

	assign reg_idx = paddr[xxtea_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (psel && penable && pwrite) begin
			key_q[reg_idx] <= pwdata;
		end
	end

	assign prdata = key_q[reg_idx];
	assign pready = 1'b1;
	assign key    = key_q;

endmodule

// ----- sv/xxtea_ctrl.sv -----
`timescale 1ns / 1ps

module xxtea_ctrl #(
	parameter int unsigned MAX_WORDS = xxtea_pkg::MAX_WORDS_DEF,
	localparam int unsigned AW = $clog2(MAX_WORDS),
	localparam int unsigned CNT_W = $clog2(MAX_WORDS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  xxtea_pkg::in_item_t               in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output xxtea_pkg::dp_cmd_t                cmd,
	output logic [AW-1:0]                     wr_addr,
	output logic [AW-1:0]                     rd_addr,
	output logic [xxtea_pkg::ROUND_W-1:0]     rounds
);

	xxtea_pkg::state_t  state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic               mode_q;
	xxtea_pkg::status_t status_q;
	logic [AW-1:0]      pos_q;
	logic [AW-1:0]      fa_q;
	logic [xxtea_pkg::ROUND_W-1:0] rounds_q;
	logic [CNT_W-1:0]   iss_q;
	logic               rd_vld_q;
	logic               rd_last_q;
	logic               out_vld_q;

	logic               accept;
	logic               room;
	logic [CNT_W-1:0]   n_new;
	xxtea_pkg::status_t status_d;
	logic [AW-1:0]      last_idx;
	logic [AW-1:0]      start_pos;
	logic               at_end;
	logic               move;
	logic               issue;
	logic [xxtea_pkg::QUOT_MAX-1:0] quot_hits;
	logic [xxtea_pkg::ROUND_W-1:0]  rounds_d;

	function automatic logic [AW-1:0] nxt(
		input logic [AW-1:0] x,
		input logic [AW-1:0] top,
		input logic          dec
	);
		logic [AW-1:0] r;
		if (dec) begin
			r = (x == '0) ? top : x - AW'(1);
		end else begin
			r = (x == top) ? '0 : x + AW'(1);
		end
		return r;
	endfunction

	assign in_ready  = (state_q == xxtea_pkg::ST_LOAD);
	assign accept    = in_valid && in_ready;
	assign room      = (count_q < CNT_W'(MAX_WORDS));
	assign n_new     = room ? count_q + CNT_W'(1) : count_q;
	assign status_d  = (ovf_q || !room) ? xxtea_pkg::STAT_LONG :
	                   (n_new < CNT_W'(2)) ? xxtea_pkg::STAT_SHORT : xxtea_pkg::STAT_DONE;
	assign last_idx  = AW'(count_q - CNT_W'(1));
	assign start_pos = mode_q ? last_idx : '0;
	assign at_end    = (pos_q == (mode_q ? '0 : last_idx));
	assign move      = (state_q == xxtea_pkg::ST_EMIT) && rd_vld_q && (!out_vld_q || out_ready);
	assign issue     = (state_q == xxtea_pkg::ST_EMIT) && (iss_q != count_q) && (!rd_vld_q || move);

	// 52/n as the count of k with k*n <= 52
	always_comb begin
		for (int k = 1; k <= xxtea_pkg::QUOT_MAX; k++) begin
			quot_hits[k-1] = (32'(count_q) * 32'(k) <= 32'(xxtea_pkg::ROUND_NUM));
		end
	end
	assign rounds_d = xxtea_pkg::ROUND_W'(xxtea_pkg::BASE_ROUNDS)
	                + xxtea_pkg::ROUND_W'($countones(quot_hits));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			xxtea_pkg::ST_LOAD: begin
				if (accept && in_item.last_word) begin
					state_d = (status_d == xxtea_pkg::STAT_DONE) ? xxtea_pkg::ST_SETUP
					                                            : xxtea_pkg::ST_EMIT;
				end
			end
			xxtea_pkg::ST_SETUP: state_d = xxtea_pkg::ST_PRIME;
			xxtea_pkg::ST_PRIME: state_d = xxtea_pkg::ST_RUN;
			xxtea_pkg::ST_RUN: begin
				if (at_end && rounds_q == xxtea_pkg::ROUND_W'(1)) begin
					state_d = xxtea_pkg::ST_EMIT;
				end
			end
			xxtea_pkg::ST_EMIT: begin
				if (move && rd_last_q) begin
					state_d = xxtea_pkg::ST_LOAD;
				end
			end
			default: state_d = xxtea_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.decrypt    = mode_q;
		cmd.pair       = (count_q == CNT_W'(2));
		cmd.key_lo     = 2'(pos_q);
		cmd.out_last   = rd_last_q;
		cmd.out_status = status_q;
		cmd.out_load   = move;
		wr_addr        = count_q[AW-1:0];
		rd_addr        = fa_q;
		unique case (state_q)
			xxtea_pkg::ST_LOAD: begin
				cmd.load_wr    = accept && room;
				cmd.load_first = accept && (count_q == '0);
			end
			xxtea_pkg::ST_SETUP: begin
				cmd.init = 1'b1;
			end
			xxtea_pkg::ST_PRIME: begin
				cmd.rd_en    = 1'b1;
				cmd.sum_init = 1'b1;
			end
			xxtea_pkg::ST_RUN: begin
				cmd.step      = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.round_end = at_end;
				wr_addr       = pos_q;
			end
			xxtea_pkg::ST_EMIT: begin
				cmd.rd_en = issue;
				rd_addr   = iss_q[AW-1:0];
			end
			default: begin
				cmd.rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= xxtea_pkg::ST_LOAD;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			mode_q    <= 1'b0;
			status_q  <= xxtea_pkg::STAT_DONE;
			pos_q     <= '0;
			fa_q      <= '0;
			rounds_q  <= '0;
			iss_q     <= '0;
			rd_vld_q  <= 1'b0;
			rd_last_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				xxtea_pkg::ST_LOAD: begin
					if (accept) begin
						if (count_q == '0) begin
							mode_q <= in_item.decrypt_mode;
						end
						if (room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_item.last_word) begin
							status_q <= status_d;
						end
					end
				end
				xxtea_pkg::ST_SETUP: begin
					pos_q    <= start_pos;
					fa_q     <= nxt(start_pos, last_idx, mode_q);
					rounds_q <= rounds_d;
				end
				xxtea_pkg::ST_PRIME: begin
					fa_q <= nxt(fa_q, last_idx, mode_q);
				end
				xxtea_pkg::ST_RUN: begin
					fa_q  <= nxt(fa_q, last_idx, mode_q);
					pos_q <= nxt(pos_q, last_idx, mode_q);
					if (at_end) begin
						rounds_q <= rounds_q - xxtea_pkg::ROUND_W'(1);
					end
				end
				xxtea_pkg::ST_EMIT: begin
					if (issue) begin
						iss_q     <= iss_q + CNT_W'(1);
						rd_last_q <= (iss_q == count_q - CNT_W'(1));
						rd_vld_q  <= 1'b1;
					end else if (move) begin
						rd_vld_q <= 1'b0;
					end
					if (move && rd_last_q) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						mode_q  <= 1'b0;
						iss_q   <= '0;
					end
				end
				default: begin
					rd_vld_q <= 1'b0;
				end
			endcase
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign rounds    = rounds_q;

endmodule

// ----- sv/xxtea_dp.sv -----
`timescale 1ns / 1ps

module xxtea_dp #(
	parameter int unsigned MAX_WORDS = xxtea_pkg::MAX_WORDS_DEF,
	localparam int unsigned AW = $clog2(MAX_WORDS)
) (
	input  logic                              clk,
	input  xxtea_pkg::dp_cmd_t                cmd,
	input  logic [AW-1:0]                     wr_addr,
	input  logic [AW-1:0]                     rd_addr,
	input  logic [xxtea_pkg::ROUND_W-1:0]     rounds,
	input  logic [xxtea_pkg::WORD_W-1:0]      in_word,
	input  xxtea_pkg::key_t                   key,
	output xxtea_pkg::out_item_t              out_item
);

	logic [xxtea_pkg::WORD_W-1:0] mem_q [MAX_WORDS];
	logic [xxtea_pkg::WORD_W-1:0] rd_q;
	logic [xxtea_pkg::WORD_W-1:0] first_q;
	logic [xxtea_pkg::WORD_W-1:0] lastw_q;
	logic [xxtea_pkg::WORD_W-1:0] own_q;
	logic [xxtea_pkg::WORD_W-1:0] carry_q;
	logic [xxtea_pkg::WORD_W-1:0] sum_q;
	xxtea_pkg::out_item_t         out_q;

	logic [xxtea_pkg::WORD_W-1:0] fetched;
	logic [xxtea_pkg::WORD_W-1:0] z;
	logic [xxtea_pkg::WORD_W-1:0] y;
	logic [xxtea_pkg::WORD_W-1:0] k;
	logic [xxtea_pkg::WORD_W-1:0] mval;
	logic [xxtea_pkg::WORD_W-1:0] new_word;
	logic [xxtea_pkg::WORD_W-1:0] wr_data;
	logic                         wr_en;

	// two-word block: the neighbor is always the other word, held in carry_q
	assign fetched  = cmd.pair ? carry_q : rd_q;
	assign z        = cmd.decrypt ? fetched : carry_q;
	assign y        = cmd.decrypt ? carry_q : fetched;
	assign k        = key[cmd.key_lo ^ sum_q[3:2]];
	assign mval     = xxtea_pkg::mix(z, y, sum_q, k);
	assign new_word = cmd.decrypt ? own_q - mval : own_q + mval;
	assign wr_en    = cmd.load_wr || cmd.step;
	assign wr_data  = cmd.step ? new_word : in_word;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			lastw_q <= in_word;
		end
		if (cmd.load_first) begin
			first_q <= in_word;
		end
		if (cmd.init) begin
			own_q   <= cmd.decrypt ? lastw_q : first_q;
			carry_q <= cmd.decrypt ? first_q : lastw_q;
		end else if (cmd.step) begin
			own_q   <= fetched;
			carry_q <= new_word;
		end
		if (cmd.sum_init) begin
			sum_q <= cmd.decrypt ? 32'(32'(rounds) * xxtea_pkg::DELTA) : xxtea_pkg::DELTA;
		end else if (cmd.round_end) begin
			sum_q <= cmd.decrypt ? sum_q - xxtea_pkg::DELTA : sum_q + xxtea_pkg::DELTA;
		end
		if (cmd.out_load) begin
			out_q.result_word  <= rd_q;
			out_q.last_result  <= cmd.out_last;
			out_q.block_status <= cmd.out_status;
		end
	end

	assign out_item = out_q;

endmodule

// ----- sv/xxtea_block_cipher.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake               transfer
// cfg       in   psel/penable/pready     key word write/read, 4 x 32 bit
// in        in   in_valid/in_ready       one block word, last flag, mode
// out       out  out_valid/out_ready     one result word, last flag, status
//
// A block of n words is loaded, set up (SETUP, PRIME) and mixed for 6+52/n rounds
// of n XXTEA steps each (one XXTEA step per cycle through the single word store
// write port), then emitted. Short and long blocks skip setup and mixing. in_ready
// is high only while loading; results leave through an output register, so
// out_ready low only stalls emission. Reset clears control and keys; the word
// store is not cleared.

module xxtea_block_cipher #(
	parameter int unsigned MAX_WORDS = xxtea_pkg::MAX_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [xxtea_pkg::ADDR_W-1:0]  paddr,
	input  logic [xxtea_pkg::WORD_W-1:0]  pwdata,
	output logic [xxtea_pkg::WORD_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  xxtea_pkg::in_item_t           in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output xxtea_pkg::out_item_t          out_data
);

	localparam int unsigned AW = $clog2(MAX_WORDS);

	xxtea_pkg::key_t               key;
	xxtea_pkg::dp_cmd_t            cmd;
	logic [AW-1:0]                 wr_addr;
	logic [AW-1:0]                 rd_addr;
	logic [xxtea_pkg::ROUND_W-1:0] rounds;

	xxtea_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.key     (key)
	);

	xxtea_ctrl #(
		.MAX_WORDS (MAX_WORDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.rounds    (rounds)
	);

	xxtea_dp #(
		.MAX_WORDS (MAX_WORDS)
	) u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.rounds   (rounds),
		.in_word  (in_data.data_word),
		.key      (key),
		.out_item (out_data)
	);

	a_no_step_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !cmd.step)
		else $error("mixing step during word load");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("output register reloaded before transfer");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && cmd.rd_en && !cmd.pair) |-> (wr_addr != rd_addr))
		else $error("store read and write hit the same word");

	a_step_reads_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !cmd.round_end) |=> (cmd.step || cmd.out_load || !cmd.rd_en))
		else $error("mixing stopped inside a round");

endmodule
